/* sv/rrle_pkg.sv */
// ----------------------------------------------------------------------------
// rrle_pkg
// shared types and constants of the raster run-length row expander
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrle_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned RUN_W   = 4;
  localparam int unsigned STAT_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COORD_W-1:0] ORIGIN_BIAS = 12'h800;

  // configuration register indexes
  localparam logic CFG_X_ORIGIN = 1'b0;
  localparam logic CFG_Y_ORIGIN = 1'b1;

  // pixel status codes
  localparam logic [STAT_W-1:0] STAT_WRITTEN = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SKIP_X  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SKIP_Y  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // sequencer to output stage
  typedef struct packed {
    logic              load;
    logic              last;
    logic [CODE_W-1:0] code;
  } seq_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ADDR_W-1:0]  addr;
    logic [STAT_W-1:0]  status;
  } pixel_t;

endpackage

/* sv/rrle_pixel_unit.sv */
// ----------------------------------------------------------------------------
// rrle_pixel_unit
// shared position unit: origin add, edge compare and linear address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrle_pixel_unit import rrle_pkg::*; #(
  parameter int unsigned RASTER_WIDTH  = 4096,
  parameter int unsigned RASTER_HEIGHT = 4096
) (
  input  logic [COORD_W-1:0] x_start,
  input  logic [COORD_W-1:0] y_start,
  input  logic [COUNT_W-1:0] column,
  input  logic [COUNT_W-1:0] row,
  output pixel_t             pixel
);

  localparam logic [SUM_W-1:0]  X_LIMIT = SUM_W'(RASTER_WIDTH);
  localparam logic [SUM_W-1:0]  Y_LIMIT = SUM_W'(RASTER_HEIGHT);
  localparam logic [ADDR_W-1:0] STRIDE  = ADDR_W'(RASTER_WIDTH);

  logic [SUM_W-1:0] px;
  logic [SUM_W-1:0] py;

  assign px = SUM_W'(x_start) + SUM_W'(column);
  assign py = SUM_W'(y_start) + SUM_W'(row);

  always_comb begin
    pixel = '0;
    if (px >= X_LIMIT) begin
      pixel.status = STAT_SKIP_X;
    end else if (py >= Y_LIMIT) begin
      pixel.status = STAT_SKIP_Y;
    end else begin
      pixel.status = STAT_WRITTEN;
      pixel.x      = px[COORD_W-1:0];
      pixel.y      = py[COORD_W-1:0];
      pixel.addr   = ADDR_W'(px[COORD_W-1:0]) + ADDR_W'(py[COORD_W-1:0]) * STRIDE;
    end
  end

endmodule

/* sv/rrle_seq.sv */
// ----------------------------------------------------------------------------
// rrle_seq
// run sequencer with column and row counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrle_seq import rrle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_eor,
  input  logic               in_eoras,
  output logic               in_ready,
  input  logic               slot_free,
  output logic [COUNT_W-1:0] column,
  output logic [COUNT_W-1:0] row,
  output seq_ctl_t           ctl
);

  seq_state_t         state;
  seq_state_t         state_next;
  logic [RUN_W-1:0]   run_left;
  logic [CODE_W-1:0]  code;
  logic               eor;
  logic               eoras;
  logic [COUNT_W-1:0] column_next;
  logic [COUNT_W-1:0] row_next;
  logic               accept;
  logic [RUN_W-1:0]   in_run;

  assign in_run = in_byte[7:4];
  assign accept = (state == ST_IDLE) && in_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && (in_run != '0)) state_next = ST_RUN;
      ST_RUN:  if (slot_free && (run_left == RUN_W'(1))) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    ctl.load = (state == ST_RUN) && slot_free;
    ctl.last = (run_left == RUN_W'(1));
    ctl.code = code;
  end

  // counter update: column steps per pixel, end marks act after the run (at once for a byte with an empty run)
  always_comb begin
    column_next = column;
    row_next    = row;
    if (accept && (in_run == '0)) begin
      if (in_eoras) begin
        column_next = '0;
        row_next    = '0;
      end else if (in_eor) begin
        column_next = '0;
        if (row != COUNT_MAX) row_next = row + 1'b1;
      end
    end else if (ctl.load) begin
      if (ctl.last && eoras) begin
        column_next = '0;
        row_next    = '0;
      end else if (ctl.last && eor) begin
        column_next = '0;
        if (row != COUNT_MAX) row_next = row + 1'b1;
      end else if (column != COUNT_MAX) begin
        column_next = column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      column <= '0;
      row    <= '0;
    end else begin
      state  <= state_next;
      column <= column_next;
      row    <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left <= '0;
    end else if (accept) begin
      run_left <= in_run;
    end else if (ctl.load) begin
      run_left <= run_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code  <= in_byte[3:0];
      eor   <= in_eor;
      eoras <= in_eoras;
    end
  end

endmodule

/* sv/raster_rle_row_expander_unit.sv */
// a taken byte is registered in the sequencer; its pixel items are then loaded into
// the output register: one pixel item per cycle from the single position unit while
//   the output slot is free, and the input is held while a byte's run is expanded
// a new byte is taken while the last pixel of the previous one still waits
// reset: synchronous, clears counters, origins, sequencer and output valid
// ----------------------------------------------------------------------------
// raster_rle_row_expander_unit
// expands run-length bytes into pixel writes on a bounded raster
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_rle_row_expander_unit import rrle_pkg::*; #(
  parameter int unsigned RASTER_WIDTH  = 4096,
  parameter int unsigned RASTER_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  // input items
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,    // rle_byte
  input  logic               s_tlast,    // end_of_row
  input  logic               s_tuser,    // end_of_raster
  // pixel items
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,    // pixel_x, pixel_y, pixel_address, pixel_code, pad
  output logic               m_tlast,    // last_of_run
  output logic [STAT_W-1:0]  m_tuser     // status
);

  // origins as written, two's complement
  logic [COORD_W-1:0] x_origin;
  logic [COORD_W-1:0] y_origin;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;

  logic [COUNT_W-1:0] column;
  logic [COUNT_W-1:0] row;
  seq_ctl_t           ctl;
  pixel_t             pixel;
  logic               slot_free;

  // output register
  pixel_t             out_pixel;
  logic [CODE_W-1:0]  out_code;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= '0;
      y_origin <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: x_origin <= cfg_data;
        CFG_Y_ORIGIN: y_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  // bias by half the coordinate span, wraps into 0..4095
  assign x_start = x_origin + ORIGIN_BIAS;
  assign y_start = y_origin + ORIGIN_BIAS;

  // output slot can take a pixel when empty or being drained
  assign slot_free = !m_tvalid || m_tready;

  rrle_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_eor    (s_tlast),
    .in_eoras  (s_tuser),
    .in_ready  (s_tready),
    .slot_free (slot_free),
    .column    (column),
    .row       (row),
    .ctl       (ctl)
  );

  rrle_pixel_unit #(
    .RASTER_WIDTH  (RASTER_WIDTH),
    .RASTER_HEIGHT (RASTER_HEIGHT)
  ) u_pixel (
    .x_start (x_start),
    .y_start (y_start),
    .column  (column),
    .row     (row),
    .pixel   (pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_pixel <= pixel;
      out_code  <= ctl.code;
      out_last  <= ctl.last;
    end
  end

  assign m_tdata = {4'b0000, out_code, out_pixel.addr, out_pixel.y, out_pixel.x};
  assign m_tlast = out_last;
  assign m_tuser = out_pixel.status;

endmodule
